// ===== hw/rtl/utf8_decode_display_width_macros.svh =====
// Assertion macros shared by the UTF-8 decoder RTL.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef UTF8_DECODE_DISPLAY_WIDTH_MACROS_SVH
`define UTF8_DECODE_DISPLAY_WIDTH_MACROS_SVH

// Check a property on every clock edge outside reset.
`define UDW_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define UDW_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/utf8dw_pkg.sv =====
// Shared types, constants and the column width table of the UTF-8 decoder.
// No dependencies; used by utf8dw_decode and utf8_decode_display_width.
package utf8dw_pkg;

	localparam int SUM_BITS = 16;
	localparam int TOTAL_W  = 16;
	localparam int CP_W     = 21;

	localparam logic [CP_W-1:0] REPLACEMENT = 21'h00FFFD;
	localparam logic [CP_W-1:0] MAX_CP      = 21'h10FFFF;
	localparam logic [CP_W-1:0] SURR_LO     = 21'h00D800;
	localparam logic [CP_W-1:0] SURR_HI     = 21'h00DFFF;
	localparam logic [CP_W-1:0] MIN_LEN2    = 21'h000080;
	localparam logic [CP_W-1:0] MIN_LEN3    = 21'h000800;
	localparam logic [CP_W-1:0] MIN_LEN4    = 21'h010000;

	localparam logic [2:0] LEN_NONE = 3'd0;
	localparam logic [2:0] LEN_1    = 3'd1;
	localparam logic [2:0] LEN_2    = 3'd2;
	localparam logic [2:0] LEN_3    = 3'd3;
	localparam logic [2:0] LEN_4    = 3'd4;

	typedef struct packed {
		logic [CP_W-1:0] lo;
		logic [CP_W-1:0] hi;
		logic [1:0]      cols;
	} utf8dw_span_t;

	localparam int N_SPANS = 26;

	localparam utf8dw_span_t WIDTH_SPANS [N_SPANS] = '{
		'{21'h00000, 21'h0001F, 2'd0}, '{21'h0007F, 21'h0009F, 2'd0},
		'{21'h00300, 21'h0036F, 2'd0}, '{21'h00483, 21'h00489, 2'd0},
		'{21'h00591, 21'h005BD, 2'd0}, '{21'h00610, 21'h0061A, 2'd0},
		'{21'h0064B, 21'h0065F, 2'd0}, '{21'h00670, 21'h00670, 2'd0},
		'{21'h006D6, 21'h006ED, 2'd0}, '{21'h01AB0, 21'h01AFF, 2'd0},
		'{21'h01DC0, 21'h01DFF, 2'd0}, '{21'h020D0, 21'h020FF, 2'd0},
		'{21'h0FE00, 21'h0FE0F, 2'd0}, '{21'h0FE20, 21'h0FE2F, 2'd0},
		'{21'hE0100, 21'hE01EF, 2'd0},
		'{21'h01100, 21'h0115F, 2'd2}, '{21'h02329, 21'h0232A, 2'd2},
		'{21'h02E80, 21'h0A4CF, 2'd2}, '{21'h0AC00, 21'h0D7A3, 2'd2},
		'{21'h0F900, 21'h0FAFF, 2'd2}, '{21'h0FE10, 21'h0FE19, 2'd2},
		'{21'h0FE30, 21'h0FE6F, 2'd2}, '{21'h0FF00, 21'h0FF60, 2'd2},
		'{21'h0FFE0, 21'h0FFE6, 2'd2}, '{21'h1F300, 21'h1FAFF, 2'd2},
		'{21'h20000, 21'h3FFFD, 2'd2}
	};

	// Decoder state between bytes.
	typedef struct packed {
		logic [2:0]      exp_len;
		logic [2:0]      seen;
		logic [CP_W-1:0] acc;
	} utf8dw_dec_t;

	// Results of one byte: n_inv invalid units, then an optional valid unit.
	typedef struct packed {
		logic [2:0]      n_inv;
		logic            tail;
		logic [CP_W-1:0] cp;
		logic [2:0]      len;
		logic [1:0]      cols;
		logic            eot;
	} utf8dw_burst_t;

	// Ranges do not overlap, so any matching span gives the answer.
	function automatic logic [1:0] col_width(input logic [CP_W-1:0] cp);
		logic [1:0] w;
		w = 2'd1;
		for (int i = N_SPANS - 1; i >= 0; i--) begin
			if (cp >= WIDTH_SPANS[i].lo && cp <= WIDTH_SPANS[i].hi) begin
				w = WIDTH_SPANS[i].cols;
			end
		end
		return w;
	endfunction

endpackage

// ===== hw/rtl/utf8dw_decode.sv =====
// Byte decode step: next decoder state and the result burst for one byte.
// Depends on utf8dw_pkg.
module utf8dw_decode (
	input  utf8dw_pkg::utf8dw_dec_t   cur,
	input  logic [7:0]                data_byte,
	input  logic                      end_of_text,
	output utf8dw_pkg::utf8dw_dec_t   nxt,
	output utf8dw_pkg::utf8dw_burst_t burst,
	output logic                      has_result
);

	logic                        cont;
	logic                        lead_go;
	logic                        bad;
	logic [2:0]                  seen_n;
	logic [utf8dw_pkg::CP_W-1:0] acc_n;

	assign cont   = (data_byte[7:6] == 2'b10);
	assign seen_n = cur.seen + 3'd1;
	assign acc_n  = {cur.acc[14:0], data_byte[5:0]};

	assign bad = (cur.exp_len == utf8dw_pkg::LEN_2 && acc_n < utf8dw_pkg::MIN_LEN2)
		|| (cur.exp_len == utf8dw_pkg::LEN_3 && acc_n < utf8dw_pkg::MIN_LEN3)
		|| (cur.exp_len == utf8dw_pkg::LEN_4 && acc_n < utf8dw_pkg::MIN_LEN4)
		|| (acc_n > utf8dw_pkg::MAX_CP)
		|| (acc_n >= utf8dw_pkg::SURR_LO && acc_n <= utf8dw_pkg::SURR_HI);

	always_comb begin
		nxt        = cur;
		burst      = '0;
		burst.eot  = end_of_text;
		burst.len  = utf8dw_pkg::LEN_1;
		lead_go    = 1'b0;
		if (cur.exp_len != utf8dw_pkg::LEN_NONE) begin
			if (cont) begin
				nxt.acc  = acc_n;
				nxt.seen = seen_n;
				if (seen_n >= cur.exp_len) begin
					nxt = '0;
					if (bad) begin
						burst.n_inv = seen_n;
					end else begin
						burst.tail = 1'b1;
						burst.cp   = acc_n;
						burst.len  = cur.exp_len;
					end
				end else if (end_of_text) begin
					burst.n_inv = seen_n;
					nxt         = '0;
				end
			end else begin
				// flush pending bytes, then treat this byte as a fresh lead
				burst.n_inv = cur.seen;
				nxt         = '0;
				lead_go     = 1'b1;
			end
		end else begin
			lead_go = 1'b1;
		end

		if (lead_go) begin
			if (!data_byte[7]) begin
				burst.tail = 1'b1;
				burst.cp   = {13'd0, data_byte};
			end else if (data_byte[7:5] == 3'b110) begin
				nxt.exp_len = utf8dw_pkg::LEN_2;
				nxt.acc     = {16'd0, data_byte[4:0]};
				nxt.seen    = 3'd1;
			end else if (data_byte[7:4] == 4'b1110) begin
				nxt.exp_len = utf8dw_pkg::LEN_3;
				nxt.acc     = {17'd0, data_byte[3:0]};
				nxt.seen    = 3'd1;
			end else if (data_byte[7:3] == 5'b11110) begin
				nxt.exp_len = utf8dw_pkg::LEN_4;
				nxt.acc     = {18'd0, data_byte[2:0]};
				nxt.seen    = 3'd1;
			end else begin
				burst.n_inv = burst.n_inv + 3'd1;
			end
			// a lead byte left open at end of text becomes one invalid unit
			if (end_of_text && nxt.exp_len != utf8dw_pkg::LEN_NONE) begin
				burst.n_inv = burst.n_inv + 3'd1;
			end
		end

		if (end_of_text) begin
			nxt = '0;
		end

		burst.cols = burst.tail ? utf8dw_pkg::col_width(burst.cp) : 2'd1;
	end

	assign has_result = burst.tail || (burst.n_inv != 3'd0);

endmodule

// ===== hw/rtl/utf8_decode_display_width.sv =====
// UTF-8 decoder with display widths: one byte per cycle in, one unit per cycle out
// unless a side stalls. Results pass the skid stage, then the sequencer; a byte
// yielding several results holds the output until each is taken. Sustained rate is
// one byte per cycle while each byte yields at most one unit and the output
// does not stall. Asynchronous active-low reset clears decoder state, the running
// width and all valid flags. Needs utf8dw_pkg, utf8dw_decode and the macros header.
`include "utf8_decode_display_width_macros.svh"

module utf8_decode_display_width (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  logic        s_axis_tlast,  // end_of_text
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [20:0] code_point, [23:21] unit_bytes, [25:24] column_width,
	// [41:26] total_width, [47:42] zero
	output logic [47:0] m_axis_tdata,
	output logic [1:0]  m_axis_tuser,  // [0] unit_valid, [1] text_done
	output logic        m_axis_tlast   // last_of_run
);

	utf8dw_pkg::utf8dw_dec_t   dec_q;
	utf8dw_pkg::utf8dw_dec_t   dec_nxt;
	utf8dw_pkg::utf8dw_burst_t dec_burst;
	logic                      dec_has_result;

	utf8dw_pkg::utf8dw_burst_t burst_s1;
	logic                      valid_s1;

	logic                        busy_q;
	logic [2:0]                  inv_left_q;
	logic                        tail_q;
	logic [utf8dw_pkg::CP_W-1:0] cp_q;
	logic [2:0]                  len_q;
	logic [1:0]                  cols_q;
	logic                        eot_q;

	logic [utf8dw_pkg::SUM_BITS-1:0] sum_q;
	logic [utf8dw_pkg::SUM_BITS:0]   sum_wide;
	logic [utf8dw_pkg::SUM_BITS-1:0] sum_sat;
	logic [31:0]                     sum_ext;

	logic                        accept;
	logic                        take;
	logic                        adv_s1;
	logic                        from_inv;
	logic                        cur_last;
	logic [1:0]                  cur_cols;
	logic [utf8dw_pkg::CP_W-1:0] cur_cp;
	logic [2:0]                  cur_len;

	utf8dw_decode u_decode (
		.cur         (dec_q),
		.data_byte   (s_axis_tdata),
		.end_of_text (s_axis_tlast),
		.nxt         (dec_nxt),
		.burst       (dec_burst),
		.has_result  (dec_has_result)
	);

	// current output unit: pending invalid units go first, then the tail unit
	assign from_inv = (inv_left_q != 3'd0);
	assign cur_last = from_inv ? (inv_left_q == 3'd1 && !tail_q) : 1'b1;
	assign cur_cols = from_inv ? 2'd1 : cols_q;
	assign cur_cp   = from_inv ? utf8dw_pkg::REPLACEMENT : cp_q;
	assign cur_len  = from_inv ? utf8dw_pkg::LEN_1 : len_q;

	assign sum_wide = {1'b0, sum_q} + (utf8dw_pkg::SUM_BITS + 1)'(cur_cols);
	assign sum_sat  = sum_wide[utf8dw_pkg::SUM_BITS] ? '1
		: sum_wide[utf8dw_pkg::SUM_BITS-1:0];
	assign sum_ext  = 32'(sum_sat);

	assign take          = busy_q && m_axis_tready;
	assign adv_s1        = !busy_q || (m_axis_tready && cur_last);
	assign s_axis_tready = !valid_s1 || adv_s1;
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign m_axis_tvalid = busy_q;
	assign m_axis_tdata  = {6'd0, sum_ext[utf8dw_pkg::TOTAL_W-1:0], cur_cols, cur_len, cur_cp};
	assign m_axis_tuser  = {cur_last && eot_q, !from_inv};
	assign m_axis_tlast  = cur_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_q      <= '0;
			valid_s1   <= 1'b0;
			busy_q     <= 1'b0;
			inv_left_q <= 3'd0;
			tail_q     <= 1'b0;
			sum_q      <= '0;
		end else begin
			if (accept) begin
				dec_q <= dec_nxt;
			end
			if (accept && dec_has_result) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (valid_s1 && adv_s1) begin
				busy_q     <= 1'b1;
				inv_left_q <= burst_s1.n_inv;
				tail_q     <= burst_s1.tail;
			end else if (take) begin
				if (cur_last) begin
					busy_q <= 1'b0;
				end else begin
					inv_left_q <= inv_left_q - 3'd1;
				end
			end
			// restart the running width after the final unit of a text
			if (take) begin
				sum_q <= (cur_last && eot_q) ? '0 : sum_sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && dec_has_result) begin
			burst_s1 <= dec_burst;
		end
		if (valid_s1 && adv_s1) begin
			cp_q   <= burst_s1.cp;
			len_q  <= burst_s1.len;
			cols_q <= burst_s1.cols;
			eot_q  <= burst_s1.eot;
		end
	end

	`UDW_ASSERT(a_pending_count, (dec_q.exp_len != utf8dw_pkg::LEN_NONE) |-> (dec_q.seen != 3'd0 && dec_q.seen < dec_q.exp_len), "pending byte count out of range")
	`UDW_ASSERT(a_burst_size, busy_q |-> ((inv_left_q != 3'd0 || tail_q) && (inv_left_q + {2'd0, tail_q}) <= 3'd4), "result burst size out of range")
	`UDW_ASSERT(a_width_restart, (take && cur_last && eot_q) |=> (sum_q == '0), "running width not cleared after end of text")
	`UDW_ASSERT(a_skid_free, !valid_s1 |-> s_axis_tready, "input stalled with empty skid stage")

endmodule

// ===== test/testbench.sv =====
// Self-checking bench for utf8_decode_display_width: UTF-8 byte stream in, decoded units out.
// A scoreboard class tracks decoder state and running widths to predict every unit.
// Depends on utf8dw_pkg and the utf8_decode_display_width RTL.
module testbench;

	localparam int unsigned STALL_LIMIT = 4000;
	localparam int unsigned PHASE_BYTES = 35;

	typedef struct {
		logic [20:0] code_point;
		logic [2:0]  unit_bytes;
		logic        unit_valid;
		logic [1:0]  column_width;
		logic [15:0] total_width;
		logic        last_of_run;
		logic        text_done;
	} unit_result_t;

	class width_ledger;
		unit_result_t awaited_units[$];
		unit_result_t burst[$];
		int unsigned errors = 0;
		logic [2:0]  seq_len = utf8dw_pkg::LEN_NONE;
		logic [2:0]  seq_seen = 3'd0;
		logic [20:0] seq_acc = 21'd0;
		logic [utf8dw_pkg::SUM_BITS-1:0] col_sum = '0;

		function bit between(logic [20:0] c, logic [20:0] lo, logic [20:0] hi);
			return c >= lo && c <= hi;
		endfunction

		function logic [1:0] columns_of(logic [20:0] c);
			if (c <= 21'h1F || between(c, 21'h7F, 21'h9F) || between(c, 21'h300, 21'h36F) ||
				between(c, 21'h483, 21'h489) || between(c, 21'h591, 21'h5BD) ||
				between(c, 21'h610, 21'h61A) || between(c, 21'h64B, 21'h65F) ||
				c == 21'h670 || between(c, 21'h6D6, 21'h6ED) ||
				between(c, 21'h1AB0, 21'h1AFF) || between(c, 21'h1DC0, 21'h1DFF) ||
				between(c, 21'h20D0, 21'h20FF) || between(c, 21'hFE00, 21'hFE0F) ||
				between(c, 21'hFE20, 21'hFE2F) || between(c, 21'hE0100, 21'hE01EF))
				return 2'd0;
			if (between(c, 21'h1100, 21'h115F) || between(c, 21'h2329, 21'h232A) ||
				between(c, 21'h2E80, 21'hA4CF) || between(c, 21'hAC00, 21'hD7A3) ||
				between(c, 21'hF900, 21'hFAFF) || between(c, 21'hFE10, 21'hFE19) ||
				between(c, 21'hFE30, 21'hFE6F) || between(c, 21'hFF00, 21'hFF60) ||
				between(c, 21'hFFE0, 21'hFFE6) || between(c, 21'h1F300, 21'h1FAFF) ||
				between(c, 21'h20000, 21'h3FFFD))
				return 2'd2;
			return 2'd1;
		endfunction

		// At most four units per byte; the width sum saturates.
		function void add_unit(logic [20:0] c, logic [2:0] len, bit ok);
			unit_result_t u;
			logic [utf8dw_pkg::SUM_BITS-1:0] top;
			if (burst.size() >= 4) return;
			top = '1;
			u.column_width = ok ? columns_of(c) : 2'd1;
			col_sum = (col_sum > top - u.column_width) ? top : col_sum + u.column_width;
			u.code_point = ok ? c : utf8dw_pkg::REPLACEMENT;
			u.unit_bytes = ok ? len : utf8dw_pkg::LEN_1;
			u.unit_valid = ok;
			u.total_width = col_sum[15:0];
			u.last_of_run = 1'b0;
			u.text_done = 1'b0;
			burst = {burst, u};
		endfunction

		function void clear_seq();
			seq_len = utf8dw_pkg::LEN_NONE;
			seq_seen = 3'd0;
			seq_acc = 21'd0;
		endfunction

		function void flush_seq();
			for (int i = 0; i < seq_seen; i++)
				add_unit(utf8dw_pkg::REPLACEMENT, utf8dw_pkg::LEN_1, 1'b0);
			clear_seq();
		endfunction

		function void take_lead(logic [7:0] b, logic last);
			if (b < 8'h80) begin
				add_unit({13'd0, b}, utf8dw_pkg::LEN_1, 1'b1);
				return;
			end
			if (b[7:5] == 3'b110) begin
				seq_len = utf8dw_pkg::LEN_2;
				seq_acc = {16'd0, b[4:0]};
			end else if (b[7:4] == 4'b1110) begin
				seq_len = utf8dw_pkg::LEN_3;
				seq_acc = {17'd0, b[3:0]};
			end else if (b[7:3] == 5'b11110) begin
				seq_len = utf8dw_pkg::LEN_4;
				seq_acc = {18'd0, b[2:0]};
			end else begin
				add_unit(utf8dw_pkg::REPLACEMENT, utf8dw_pkg::LEN_1, 1'b0);
				return;
			end
			seq_seen = 3'd1;
			if (last) flush_seq();
		endfunction

		function void note_byte(logic [7:0] b, logic last);
			logic [20:0] v;
			bit bad;
			burst.delete();
			if (seq_len != utf8dw_pkg::LEN_NONE) begin
				if (b[7:6] == 2'b10) begin
					seq_acc = {seq_acc[14:0], b[5:0]};
					seq_seen = seq_seen + 3'd1;
					if (seq_seen >= seq_len) begin
						v = seq_acc;
						bad = (seq_len == utf8dw_pkg::LEN_2 && v < utf8dw_pkg::MIN_LEN2) ||
							(seq_len == utf8dw_pkg::LEN_3 && v < utf8dw_pkg::MIN_LEN3) ||
							(seq_len == utf8dw_pkg::LEN_4 && v < utf8dw_pkg::MIN_LEN4) ||
							v > utf8dw_pkg::MAX_CP ||
							(v >= utf8dw_pkg::SURR_LO && v <= utf8dw_pkg::SURR_HI);
						if (bad) begin
							flush_seq();
						end else begin
							add_unit(v, seq_len, 1'b1);
							clear_seq();
						end
					end else if (last) begin
						flush_seq();
					end
				end else begin
					// bad continuation: drop the pending bytes, then restart on this one
					flush_seq();
					take_lead(b, last);
				end
			end else begin
				take_lead(b, last);
			end
			if (burst.size() > 0) begin
				burst[burst.size() - 1].last_of_run = 1'b1;
				burst[burst.size() - 1].text_done = last;
			end
			if (last) begin
				clear_seq();
				col_sum = '0;
			end
			awaited_units = {awaited_units, burst};
		endfunction

		function void compare(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_unit(unit_result_t got);
			unit_result_t want;
			if (awaited_units.size() == 0) begin
				$error("unit 0x%0h arrived with none awaited", got.code_point);
				errors++;
				return;
			end
			want = awaited_units.pop_front();
			compare("code_point", want.code_point, got.code_point);
			compare("unit_bytes", want.unit_bytes, got.unit_bytes);
			compare("unit_valid", want.unit_valid, got.unit_valid);
			compare("column_width", want.column_width, got.column_width);
			compare("total_width", want.total_width, got.total_width);
			compare("last_of_run", want.last_of_run, got.last_of_run);
			compare("text_done", want.text_done, got.text_done);
		endfunction

		function int unsigned outstanding();
			return awaited_units.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'd0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;

	width_ledger ledger = new();
	int unsigned send_idle_pct = 0;
	int unsigned take_stall_pct = 0;
	int unsigned bytes_sent = 0;
	int unsigned quiet_cycles = 0;

	// Table boundaries and encoding limits, each probed with a neighbour either side.
	int unsigned cp_edges[30] = '{
		'h80, 'h7FF, 'h800, 'h300, 'h36F, 'h670, 'h1100, 'h115F, 'h2329, 'h2E80,
		'hA4CF, 'hAC00, 'hD7A3, 'hD7FF, 'hE000, 'hFE00, 'hFE0F, 'hFE10, 'hFE19,
		'hFF60, 'hFFE6, 'hFFFF, 'h10000, 'h1F300, 'h1FAFF, 'h20000, 'h3FFFD,
		'hE0100, 'hE01EF, 'h10FFFF
	};

	utf8_decode_display_width dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= take_stall_pct);
	end

	always @(posedge clk) begin
		unit_result_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.code_point = m_axis_tdata[20:0];
			got.unit_bytes = m_axis_tdata[23:21];
			got.column_width = m_axis_tdata[25:24];
			got.total_width = m_axis_tdata[41:26];
			got.unit_valid = m_axis_tuser[0];
			got.text_done = m_axis_tuser[1];
			got.last_of_run = m_axis_tlast;
			ledger.check_unit(got);
		end
	end

	// End the run once no transaction has happened on either side for too long.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("utf8_decode_display_width test failed");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
		ledger.note_byte(b, last);
		bytes_sent++;
	endtask

	function automatic int unsigned natural_len(int unsigned cp);
		if (cp < 'h80) return 1;
		if (cp < 'h800) return 2;
		if (cp < 'h10000) return 3;
		return 4;
	endfunction

	function automatic void encode_cp(input int unsigned cp, input int unsigned len,
		output logic [7:0] q[$]);
		logic [20:0] c;
		c = cp[20:0];
		q.delete();
		case (len)
			1: q = {q, {1'b0, c[6:0]}};
			2: q = {q, {3'b110, c[10:6]}};
			3: q = {q, {4'b1110, c[15:12]}};
			default: begin
				q = {q, {5'b11110, c[20:18]}};
				q = {q, {2'b10, c[17:12]}};
			end
		endcase
		if (len >= 3) q = {q, {2'b10, c[11:6]}};
		if (len >= 2) q = {q, {2'b10, c[5:0]}};
	endfunction

	// One unit of random text: mostly well formed, with overlong, out-of-range,
	// noise, broken and truncated sequences mixed in.
	task automatic send_unit();
		logic [7:0] seq[$];
		logic [7:0] odd;
		int unsigned kind, cp, len, pos;
		bit end_here;
		kind = $urandom_range(99);
		end_here = ($urandom_range(4) == 0);
		if (kind < 15) begin
			cp = $urandom_range(127);
			len = 1;
		end else if (kind < 45) begin
			cp = cp_edges[$urandom_range(29)] + $urandom_range(2) - 1;
			len = natural_len(cp);
		end else if (kind < 60) begin
			len = $urandom_range(4, 2);
			cp = (len == 2) ? $urandom_range('h7FF, 'h80) :
				(len == 3) ? $urandom_range('hFFFF, 'h800) : $urandom_range('h10FFFF, 'h10000);
		end else if (kind < 68) begin
			cp = $urandom_range('hFFFF);
			len = $urandom_range(4, natural_len(cp) + 1 > 4 ? 4 : natural_len(cp) + 1);
			if (len == natural_len(cp)) cp = cp & 'h7FF;
		end else if (kind < 74) begin
			cp = $urandom_range('hDFFF, 'hD800);
			len = 3;
		end else if (kind < 80) begin
			cp = $urandom_range('h1FFFFF, 'h110000);
			len = 4;
		end else begin
			cp = $urandom_range('h10FFFF, 'h80);
			len = natural_len(cp);
		end
		encode_cp(cp, len, seq);
		if (kind >= 80 && kind < 88) begin
			seq.delete();
			seq = {seq, 8'($urandom_range(255))};
		end else if (kind >= 88 && kind < 94) begin
			pos = $urandom_range(len - 1, 1);
			odd = $urandom_range(255);
			if (odd[7:6] == 2'b10) odd = odd ^ 8'h40;
			seq[pos] = odd;
		end else if (kind >= 94) begin
			while (seq.size() > $urandom_range(len - 1, 1)) void'(seq.pop_back());
		end
		foreach (seq[i]) send_byte(seq[i], end_here && i == seq.size() - 1);
	endtask

	task automatic settle();
		@(negedge clk) s_axis_tvalid <= 1'b0;
		while (ledger.outstanding() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic random_phase(input int unsigned idle_pct, input int unsigned stall_pct);
		int unsigned start;
		send_idle_pct = idle_pct;
		take_stall_pct = stall_pct;
		start = bytes_sent;
		while (bytes_sent - start < PHASE_BYTES) send_unit();
		settle();
	endtask

	// The lowest ASCII byte, a combining mark, wide and maximum scalars, stray and
	// invalid leads, overlong, above-range, surrogate, broken and truncated forms.
	logic [7:0] opening[25] = '{
		8'h00, 8'hCC, 8'h81, 8'hE4, 8'hB8, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF,
		8'h80, 8'hFF, 8'hC0, 8'h80, 8'hF5, 8'h80, 8'h80, 8'h80, 8'hED, 8'hA0,
		8'h80, 8'hE4, 8'h41, 8'hE4, 8'hB8
	};

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		foreach (opening[i]) send_byte(opening[i], i == 24);
		settle();

		random_phase(0, 0);
		random_phase(88, 0);
		random_phase(0, 88);
		random_phase(28, 28);
		random_phase(0, 0);

		if (ledger.errors == 0 && ledger.outstanding() == 0)
			$display("utf8_decode_display_width test passed");
		else
			$display("utf8_decode_display_width test failed");
		$finish;
	end
endmodule
